FILE: hw/rtl/htfd_pkg.sv
package htfd_pkg;

    // CRC-8 over each 16-bit word: polynomial 0x31, seed 0xFF
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Scale factors applied before the divide by 65535; offset and ceiling after it
    localparam logic [14:0] TEMP_SCALE   = 15'd17500;
    localparam logic [14:0] HUM_SCALE    = 15'd10000;
    localparam logic [14:0] TEMP_OFFSET  = 15'd4500;
    localparam logic [14:0] HUM_CEILING  = 15'd10000;
    localparam logic [16:0] WORD_DIVISOR = 17'd65535;

    // Configuration register indexes
    localparam logic [7:0] REG_TEMP_EN  = 8'd0;
    localparam logic [7:0] REG_HUM_EN   = 8'd1;
    localparam logic [7:0] REG_TEMP_EP  = 8'd2;
    localparam logic [7:0] REG_HUM_EP   = 8'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CRC_FAIL = 2'd1;
    localparam logic [1:0] STATUS_READ_ERR = 2'd2;

    // Quantity codes
    localparam logic QTY_TEMP = 1'b0;
    localparam logic QTY_HUM  = 1'b1;

    // Output queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0]        endpoint;
        logic               quantity;
        logic signed [14:0] reading;
        logic [1:0]         status;
        logic               last;
    } htfd_result_t;

    // One byte through the CRC-8 register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/humidity_temp_frame_decoder.sv
// Temperature / humidity frame decoder.
// Input channel (in_valid/in_ready): one frame byte per word on rx_byte, in the
// order temperature MSB, LSB, CRC, then humidity MSB, LSB, CRC. read_failed
// aborts the frame and yields a read-failed result for each enabled quantity.
// Output channel (out_valid/out_ready): one result per word; last marks the
// final result caused by one input word. Each CRC byte gives at most one.
// Config channel (cfg_valid/cfg_ready): index 0/1 report enables, 2/3
// endpoints; other indexes are ignored. cfg_ready is always high.
// A result passes through the decode register, then the four-entry result
// queue, before it is presented.
// Throughput: one input word per cycle while in_ready is high; one result
// leaves per cycle, so a read failure with both quantities enabled gives two
// in turn. The multiply-by-scale and divide-by-65535 fit one stage.
// Reset: frame position back to the temperature MSB, CRC seed 0xFF, enables
// set, endpoints zero, queue empty.
// Stall: when out_ready is low the queue fills; in_ready drops once fewer
// than two free entries remain beyond what the decode register will write.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // frame bytes
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               read_failed,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        endpoint,
    output logic               quantity,
    output logic signed [14:0] reading,
    output logic [1:0]         status,
    output logic               last,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Frame positions
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic        temp_en_reg;
    logic        hum_en_reg;
    logic [15:0] temp_ep_reg;
    logic [15:0] hum_ep_reg;

    logic [2:0]  byte_pos_reg, byte_pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] raw_reg, raw_next;
    logic [2:0]  pos_eff;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_fail_reg;
    logic        s1_hum_reg;
    logic        s1_ok_reg;
    logic [15:0] s1_raw_reg;

    htfd_result_t            queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic [QPTR_W-1:0]       wr_ptr_second;

    logic        in_accept;
    logic        out_pop;
    logic        is_check;
    logic [1:0]  s1_n;

    logic [14:0] scale;
    logic [30:0] product;
    logic [14:0] prod_hi;
    logic [16:0] fold_sum;
    logic [14:0] quotient;
    logic [14:0] conv_reading;

    htfd_result_t res_first;
    htfd_result_t res_second;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign out_pop   = out_valid && out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_en_reg <= 1'b1;
            hum_en_reg  <= 1'b1;
            temp_ep_reg <= 16'd0;
            hum_ep_reg  <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TEMP_EN: temp_en_reg <= cfg_data[0];
                REG_HUM_EN:  hum_en_reg  <= cfg_data[0];
                REG_TEMP_EP: temp_ep_reg <= cfg_data;
                REG_HUM_EP:  hum_ep_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Frame tracking: position, running CRC and assembled word
    always_comb
    begin
        pos_eff       = (byte_pos_reg > POS_H_CRC) ? POS_T_MSB : byte_pos_reg;
        byte_pos_next = byte_pos_reg;
        crc_next      = crc_reg;
        raw_next      = raw_reg;
        is_check      = 1'b0;
        if (read_failed)
        begin
            byte_pos_next = POS_T_MSB;
            crc_next      = CRC_INIT;
            raw_next      = 16'd0;
        end
        else
        begin
            case (pos_eff)
                POS_T_MSB, POS_H_MSB:
                begin
                    crc_next      = crc8_byte(CRC_INIT, rx_byte);
                    raw_next      = {rx_byte, 8'd0};
                    byte_pos_next = pos_eff + 3'd1;
                end
                POS_T_LSB, POS_H_LSB:
                begin
                    crc_next      = crc8_byte(crc_reg, rx_byte);
                    raw_next      = {raw_reg[15:8], raw_reg[7:0] | rx_byte};
                    byte_pos_next = pos_eff + 3'd1;
                end
                default:
                begin
                    is_check      = 1'b1;
                    crc_next      = CRC_INIT;
                    raw_next      = 16'd0;
                    byte_pos_next = (pos_eff == POS_H_CRC) ? POS_T_MSB : POS_H_MSB;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= POS_T_MSB;
            crc_reg      <= CRC_INIT;
            raw_reg      <= 16'd0;
        end
        else if (in_accept)
        begin
            byte_pos_reg <= byte_pos_next;
            crc_reg      <= crc_next;
            raw_reg      <= raw_next;
        end
    end

    // Decode register: words that produce results
    assign s1_valid_next = in_accept && (read_failed || is_check);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_fail_reg <= read_failed;
            s1_hum_reg  <= (pos_eff == POS_H_CRC);
            s1_ok_reg   <= (crc_reg == rx_byte);
            s1_raw_reg  <= raw_reg;
        end
    end

    // Conversion: floor(scale*raw/65535) as hi + (hi + lo >= 65535)
    always_comb
    begin
        scale    = s1_hum_reg ? HUM_SCALE : TEMP_SCALE;
        product  = 31'(s1_raw_reg) * 31'(scale);
        prod_hi  = product[30:16];
        fold_sum = {2'b00, prod_hi} + {1'b0, product[15:0]};
        quotient = prod_hi + 15'(fold_sum >= WORD_DIVISOR);
        if (!s1_ok_reg)
            conv_reading = 15'd0;
        else if (s1_hum_reg)
            conv_reading = (quotient > HUM_CEILING) ? HUM_CEILING : quotient;
        else
            conv_reading = quotient - TEMP_OFFSET;
    end

    // Results for the word in the decode register
    always_comb
    begin
        res_first  = '0;
        res_second = '0;
        s1_n       = 2'd0;
        if (s1_valid_reg)
        begin
            if (s1_fail_reg)
            begin
                s1_n = {1'b0, temp_en_reg} + {1'b0, hum_en_reg};
                res_first.endpoint  = temp_en_reg ? temp_ep_reg : hum_ep_reg;
                res_first.quantity  = temp_en_reg ? QTY_TEMP : QTY_HUM;
                res_first.reading   = 15'sd0;
                res_first.status    = STATUS_READ_ERR;
                res_first.last      = !(temp_en_reg && hum_en_reg);
                res_second.endpoint = hum_ep_reg;
                res_second.quantity = QTY_HUM;
                res_second.reading  = 15'sd0;
                res_second.status   = STATUS_READ_ERR;
                res_second.last     = 1'b1;
            end
            else
            begin
                s1_n = {1'b0, s1_hum_reg ? hum_en_reg : temp_en_reg};
                res_first.endpoint = s1_hum_reg ? hum_ep_reg : temp_ep_reg;
                res_first.quantity = s1_hum_reg ? QTY_HUM : QTY_TEMP;
                res_first.reading  = conv_reading;
                res_first.status   = s1_ok_reg ? STATUS_OK : STATUS_CRC_FAIL;
                res_first.last     = 1'b1;
            end
        end
    end

    // Result queue
    assign wr_ptr_second = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(s1_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(out_pop);
        count_next  = count_reg + QCNT_W'(s1_n) - QCNT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_n != 2'd0)
            queue_reg[wr_ptr_reg] <= res_first;
        if (s1_n == 2'd2)
            queue_reg[wr_ptr_second] <= res_second;
    end

    // Room for two more results beyond what is queued or in flight
    assign in_ready = ({1'b0, count_reg} + (QCNT_W + 1)'(s1_n))
                      <= (QCNT_W + 1)'(QUEUE_DEPTH - 2);

    assign out_valid = (count_reg != '0);
    assign endpoint  = queue_reg[rd_ptr_reg].endpoint;
    assign quantity  = queue_reg[rd_ptr_reg].quantity;
    assign reading   = queue_reg[rd_ptr_reg].reading;
    assign status    = queue_reg[rd_ptr_reg].status;
    assign last      = queue_reg[rd_ptr_reg].last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= POS_H_CRC)
        else $error("frame position out of range");

    a_fail_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && read_failed |=>
            byte_pos_reg == POS_T_MSB && crc_reg == CRC_INIT)
        else $error("read failure did not restart the frame");
`endif

endmodule
